// ===== hdl/plst_pkg.sv =====
// Shared types and constants of the positional list store.
`default_nettype none
package plst_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int MODE_W = 3;
   localparam int HANDLE_W = 32;
   localparam int POS_W = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD_HEAD = 3'd0,
      MODE_ADD_TAIL = 3'd1,
      MODE_ADD_AT   = 3'd2,
      MODE_REM_HEAD = 3'd3,
      MODE_REM_TAIL = 3'd4,
      MODE_REM_AT   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic execute;
      logic publish;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/plst_ctrl.sv =====
// Sequencing state machine of the positional list store.
`default_nettype none
module plst_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  plst_pkg::sts_type   sts,
   output plst_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            // refuse transfers while reset is high
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/plst_dpath.sv =====
// Row of list cells, operation decode and result register.
`default_nettype none
module plst_dpath #(
   parameter int CAPACITY = plst_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  plst_pkg::cmd_type                    cmd,
   output plst_pkg::sts_type                    sts,
   input  wire logic [plst_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [plst_pkg::HANDLE_W-1:0]   req_item_handle,
   input  wire logic [plst_pkg::POS_W-1:0]      req_position,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [plst_pkg::STATUS_W-1:0]        rsp_status,
   output logic [plst_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [plst_pkg::HANDLE_W-1:0]        rsp_first_handle,
   output logic [plst_pkg::HANDLE_W-1:0]        rsp_last_handle
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > plst_pkg::POS_W) ? CNT_W : plst_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   logic [plst_pkg::MODE_W-1:0]   mode_ff;
   logic [plst_pkg::HANDLE_W-1:0] handle_ff;
   logic [plst_pkg::POS_W-1:0]    pos_ff;

   logic [plst_pkg::HANDLE_W-1:0] slots_ff [CAPACITY];
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   plst_pkg::status_type          status_ff, status_in;

   logic                          out_valid_ff;
   logic [plst_pkg::STATUS_W-1:0] out_status_ff;
   logic [plst_pkg::COUNT_W-1:0]  out_count_ff;
   logic [plst_pkg::HANDLE_W-1:0] out_first_ff, out_last_ff;

   logic             do_ins, do_rem;
   logic [CMP_W-1:0] op_pos;
   logic [CMP_W-1:0] cnt_x;
   logic [IDX_W-1:0] last_idx;

   assign cnt_x = CMP_W'(cnt_ff);

   // Decode the captured operation against the current count.
   always_comb begin
      do_ins = 1'b0;
      do_rem = 1'b0;
      op_pos = CMP_W'(pos_ff);
      status_in = plst_pkg::ST_DONE;
      case (mode_ff)
         plst_pkg::MODE_ADD_HEAD, plst_pkg::MODE_ADD_TAIL, plst_pkg::MODE_ADD_AT: begin
            if (mode_ff == plst_pkg::MODE_ADD_HEAD) begin
               op_pos = '0;
            end else if (mode_ff == plst_pkg::MODE_ADD_TAIL) begin
               op_pos = cnt_x;
            end
            if (cnt_x >= CAP_C) begin
               status_in = plst_pkg::ST_FULL;
            end else if (op_pos > cnt_x) begin
               status_in = plst_pkg::ST_IGNORED;
            end else begin
               do_ins = 1'b1;
            end
         end
         plst_pkg::MODE_REM_HEAD, plst_pkg::MODE_REM_TAIL, plst_pkg::MODE_REM_AT: begin
            if (mode_ff == plst_pkg::MODE_REM_HEAD) begin
               op_pos = '0;
            end else if (mode_ff == plst_pkg::MODE_REM_TAIL) begin
               op_pos = cnt_x - CMP_W'(1);
            end
            if (cnt_ff == '0) begin
               status_in = plst_pkg::ST_IGNORED;
            end else if (op_pos >= cnt_x) begin
               status_in = plst_pkg::ST_IGNORED;
            end else begin
               do_rem = 1'b1;
            end
         end
         default: begin
            status_in = plst_pkg::ST_IGNORED;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (do_ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rem) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Each cell keeps, takes the new handle, or shifts from a neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [plst_pkg::HANDLE_W-1:0] below, above;
      if (i == 0) begin : g_first
         assign below = slots_ff[0];
      end else begin : g_mid
         assign below = slots_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign above = slots_ff[i];
      end else begin : g_up
         assign above = slots_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            if (do_ins) begin
               if (CMP_W'(i) == op_pos) begin
                  slots_ff[i] <= handle_ff;
               end else if (CMP_W'(i) > op_pos) begin
                  slots_ff[i] <= below;
               end
            end else if (do_rem && (CMP_W'(i) >= op_pos)) begin
               slots_ff[i] <= above;
            end
         end
      end
   end

   assign last_idx = IDX_W'(cnt_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         handle_ff <= req_item_handle;
         pos_ff <= req_position;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
      end
      if (cmd.publish) begin
         out_status_ff <= status_ff;
         out_count_ff <= cnt_x[plst_pkg::COUNT_W-1:0];
         if (cnt_ff == '0) begin
            out_first_ff <= '0;
            out_last_ff <= '0;
         end else begin
            out_first_ff <= slots_ff[0];
            out_last_ff <= slots_ff[last_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            cnt_ff <= cnt_in;
         end
         if (cmd.publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_first_handle = out_first_ff;
   assign rsp_last_handle = out_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_x <= CAP_C)
      else $error("entry count above capacity");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && do_ins) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not advance the count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (cmd.publish && (status_ff == plst_pkg::ST_FULL)) |-> (cnt_x == CAP_C))
      else $error("full status reported on a list with room");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !cmd.publish)
      else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== hdl/positional_list_store.sv =====
// Top level of the positional list store: controller plus cell datapath.
//
// Bounded ordered list of 32-bit handles. Each transfer on the req_ channel
// carries one operation (req_mode): add at head, tail or req_position, or
// remove at head, tail or req_position. Each operation yields exactly one
// transfer on the rsp_ channel with the status, the entry count and the
// first and last handles after the operation (zero handles when empty).
// Both channels are valid/ready; a transfer happens when both are high.
// An operation runs through capture, update of the cell row (all entries
// shift at once), and load of the result register. The result register is
// loaded after the cell row update, and a new request is taken only once
// the previous result has been loaded into the output register.
// The result register decouples the sides: a new request is accepted while
// a result waits; if the receiver stalls, the next result holds in the
// controller's load state until the output register frees up.
// Synchronous reset empties the list and drops any pending result; req_ready
// stays low while reset is high. The cell contents are not cleared and are
// only read below the entry count.
`default_nettype none
module positional_list_store #(
   parameter int CAPACITY = plst_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [plst_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [plst_pkg::HANDLE_W-1:0]   req_item_handle,
   input  wire logic [plst_pkg::POS_W-1:0]      req_position,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [plst_pkg::STATUS_W-1:0]        rsp_status,
   output logic [plst_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic [plst_pkg::HANDLE_W-1:0]        rsp_first_handle,
   output logic [plst_pkg::HANDLE_W-1:0]        rsp_last_handle
);

   plst_pkg::cmd_type cmd;
   plst_pkg::sts_type sts;

   plst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   plst_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_item_handle  (req_item_handle),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_first_handle (rsp_first_handle),
      .rsp_last_handle  (rsp_last_handle)
   );

endmodule
`default_nettype wire

// ===== bench/positional_list_store_test.sv =====
// Self-checking testbench for positional_list_store: list predictor, driver, monitor.
module positional_list_store_test;

   localparam int LIST_DEPTH = plst_pkg::DEFAULT_CAPACITY;
   localparam int MODE_W = plst_pkg::MODE_W;
   localparam int HANDLE_W = plst_pkg::HANDLE_W;
   localparam int POS_W = plst_pkg::POS_W;
   localparam int STATUS_W = plst_pkg::STATUS_W;
   localparam int COUNT_W = plst_pkg::COUNT_W;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
   localparam int RANDOM_OPS = 2000;
   localparam int QUIET_TAIL = 150;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] handle;
      logic [POS_W-1:0]    position;
      bit                  drain;
   } list_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [HANDLE_W-1:0] first;
      logic [HANDLE_W-1:0] last;
   } list_view_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = plst_pkg::MODE_ADD_HEAD;
   logic [HANDLE_W-1:0] req_item_handle = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [HANDLE_W-1:0] rsp_first_handle;
   logic [HANDLE_W-1:0] rsp_last_handle;

   positional_list_store dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_item_handle  (req_item_handle),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_first_handle (rsp_first_handle),
      .rsp_last_handle  (rsp_last_handle)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted list contents.
   logic [HANDLE_W-1:0] list_slot [LIST_DEPTH];
   int                  list_len;

   list_op_type   pending_ops [$];
   list_view_type awaited_views [$];
   bit         fill_done = 1'b0;
   int         fails = 0;
   int         sent_ops = 0;
   int         checked_views = 0;
   int         cycles = 0;
   int         n_added = 0;
   int         n_removed = 0;
   int         n_full = 0;
   int         n_ignored = 0;
   int         peak_len = 0;

   function automatic list_view_type apply_list_op(logic [MODE_W-1:0] mode,
                                                   logic [HANDLE_W-1:0] handle,
                                                   logic [POS_W-1:0] position);
      list_view_type view;
      int where;
      view.status = plst_pkg::ST_DONE;
      case (mode)
         plst_pkg::MODE_ADD_HEAD, plst_pkg::MODE_ADD_TAIL, plst_pkg::MODE_ADD_AT: begin
            if (list_len >= LIST_DEPTH) begin
               view.status = plst_pkg::ST_FULL;
            end else begin
               where = (mode == plst_pkg::MODE_ADD_HEAD) ? 0 :
                       (mode == plst_pkg::MODE_ADD_TAIL) ? list_len : int'(position);
               if (where > list_len) begin
                  view.status = plst_pkg::ST_IGNORED;
               end else begin
                  for (int i = list_len; i > where; i--)
                     list_slot[i] = list_slot[i-1];
                  list_slot[where] = handle;
                  list_len++;
               end
            end
         end
         plst_pkg::MODE_REM_HEAD, plst_pkg::MODE_REM_TAIL, plst_pkg::MODE_REM_AT: begin
            where = (mode == plst_pkg::MODE_REM_HEAD) ? 0 :
                    (mode == plst_pkg::MODE_REM_TAIL) ? list_len - 1 : int'(position);
            if (list_len == 0 || where >= list_len) begin
               view.status = plst_pkg::ST_IGNORED;
            end else begin
               for (int i = where; i + 1 < list_len; i++)
                  list_slot[i] = list_slot[i+1];
               list_len--;
            end
         end
         default: view.status = plst_pkg::ST_IGNORED;
      endcase
      view.count = list_len[COUNT_W-1:0];
      view.first = (list_len == 0) ? '0 : list_slot[0];
      view.last  = (list_len == 0) ? '0 : list_slot[list_len-1];
      return view;
   endfunction

   task automatic note_failure(string msg);
      fails++;
      if (fails <= 10)
         $display("ERROR: %s", msg);
   endtask

   task automatic queue_op(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                           logic [POS_W-1:0] position, bit drain = 1'b0);
      list_op_type op;
      op.mode = mode;
      op.handle = handle;
      op.position = position;
      op.drain = drain;
      pending_ops.push_back(op);
   endtask

   // Driver: present the next operation, with random gaps between transfers.
   int gap_left = 0;
   always @(posedge clock) begin
      list_op_type op;
      bit quiet;
      quiet = fill_done && pending_ops.size() < QUIET_TAIL;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_ops[0].drain && (req_valid || awaited_views.size() != 0)) begin
            // hold off until every outstanding result has come back
            req_valid <= 1'b0;
         end else begin
            op = pending_ops.pop_front();
            req_mode <= op.mode;
            req_item_handle <= op.handle;
            req_position <= op.position;
            req_valid <= 1'b1;
            sent_ops++;
            if (!quiet && (sent_ops / 128) % 4 != 3 && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 11);
         end
      end
   end

   // Receiver: stall rsp_ready in random bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      bit quiet;
      quiet = fill_done && pending_ops.size() < QUIET_TAIL;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && (checked_views / 100) % 4 != 1 && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on each request transfer, check each result transfer.
   always @(posedge clock) begin
      list_view_type view;
      list_view_type got;
      if (reset) begin
         list_len = 0;
         awaited_views.delete();
      end else begin
         if (req_valid && req_ready) begin
            view = apply_list_op(req_mode, req_item_handle, req_position);
            awaited_views.push_back(view);
            if (view.status == plst_pkg::ST_FULL) n_full++;
            else if (view.status == plst_pkg::ST_IGNORED) n_ignored++;
            else if (req_mode <= plst_pkg::MODE_ADD_AT) n_added++;
            else n_removed++;
            if (list_len > peak_len) peak_len = list_len;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_entry_count, rsp_first_handle, rsp_last_handle};
            if (awaited_views.size() == 0) begin
               note_failure($sformatf("result with none outstanding: status %0d count %0d",
                                      rsp_status, rsp_entry_count));
            end else begin
               view = awaited_views.pop_front();
               if (got !== view)
                  note_failure($sformatf({"result %0d: expected status %0d count %0d ",
                     "first %h last %h, got status %0d count %0d first %h last %h"},
                     checked_views, view.status, view.count, view.first, view.last,
                     got.status, got.count, got.first, got.last));
            end
            checked_views++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_views.size());
         $display("positional_list_store verification failed");
         $finish;
      end
   end

   initial begin
      int run_len;
      bit grow;
      int pick;
      logic [MODE_W-1:0] mode;
      logic [HANDLE_W-1:0] handle;
      logic [POS_W-1:0] position;
      int made;

      // Directed: empty-list removals, unknown modes, range edges, each operation.
      queue_op(plst_pkg::MODE_REM_HEAD, 32'h0, 5'd0);
      queue_op(plst_pkg::MODE_REM_TAIL, 32'h0, 5'd0);
      queue_op(plst_pkg::MODE_REM_AT, 32'h0, 5'd0);
      queue_op(MODE_UNUSED_LO, 32'h1111_1111, 5'd0);
      queue_op(MODE_UNUSED_HI, 32'hFFFF_FFFF, 5'd31);
      queue_op(plst_pkg::MODE_ADD_AT, 32'hDEAD_BEEF, 5'd1);
      queue_op(plst_pkg::MODE_ADD_AT, 32'h0000_0000, 5'd0);
      queue_op(plst_pkg::MODE_ADD_HEAD, 32'hFFFF_FFFF, 5'd0);
      queue_op(plst_pkg::MODE_ADD_TAIL, 32'h1234_5678, 5'd31);
      queue_op(plst_pkg::MODE_ADD_AT, 32'hA5A5_A5A5, 5'd3);
      queue_op(plst_pkg::MODE_ADD_AT, 32'h5A5A_5A5A, 5'd2);
      queue_op(plst_pkg::MODE_ADD_AT, 32'h0BAD_0BAD, 5'd31);
      queue_op(plst_pkg::MODE_REM_AT, 32'h0, 5'd5);
      queue_op(plst_pkg::MODE_REM_AT, 32'h0, 5'd31);
      queue_op(plst_pkg::MODE_REM_AT, 32'h0, 5'd2);
      queue_op(plst_pkg::MODE_REM_HEAD, 32'hFFFF_FFFF, 5'd0);
      queue_op(plst_pkg::MODE_REM_TAIL, 32'h0, 5'd0);
      queue_op(plst_pkg::MODE_REM_AT, 32'h0, 5'd0);
      queue_op(plst_pkg::MODE_REM_TAIL, 32'h0, 5'd0);
      queue_op(plst_pkg::MODE_REM_HEAD, 32'h0, 5'd0);

      // Random: alternate filling and draining runs so both full and empty are hit often.
      made = 0;
      grow = 1'b1;
      while (made < RANDOM_OPS) begin
         run_len = $urandom_range(20, 60);
         for (int k = 0; k < run_len && made < RANDOM_OPS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
               mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else if ((pick < 85) == grow)
               mode = 3'($urandom_range(plst_pkg::MODE_ADD_HEAD, plst_pkg::MODE_ADD_AT));
            else
               mode = 3'($urandom_range(plst_pkg::MODE_REM_HEAD, plst_pkg::MODE_REM_AT));
            case ($urandom_range(0, 15))
               0: handle = '0;
               1: handle = '1;
               default: handle = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
               position = 5'($urandom_range(17, 31));
            else
               position = 5'($urandom_range(0, $urandom_range(0, LIST_DEPTH)));
            queue_op(mode, handle, position, made == 0 || $urandom_range(0, 199) == 0);
            made++;
         end
         grow = !grow;
      end
      fill_done = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || awaited_views.size() != 0)
         @(posedge clock);
      // let any stray result surface
      repeat (10) @(posedge clock);

      $display("checked %0d results over %0d cycles: %0d adds, %0d removes done",
               checked_views, cycles, n_added, n_removed);
      $display("%0d adds refused on a full list, %0d operations ignored, peak fill %0d of %0d",
               n_full, n_ignored, peak_len, LIST_DEPTH);
      if (fails == 0) begin
         $display("positional_list_store verification clean");
      end else begin
         $display("%0d failures", fails);
         $display("positional_list_store verification failed");
      end
      $finish;
   end

endmodule

// ===== positional_list_store.f =====
hdl/plst_pkg.sv
hdl/plst_ctrl.sv
hdl/plst_dpath.sv
hdl/positional_list_store.sv
bench/positional_list_store_test.sv
